// ----- design/cac_pkg.sv -----
// Shared constants for the cube address generator.
// Field widths, action codes and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cac_pkg;

    // Fixed field widths
    localparam int CNT_IN_W    = 9;
    localparam int UA_W        = 31;
    localparam int OUT_TDATA_W = ((UA_W + 7) / 8) * 8;

    // Action codes carried in the input tuser
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUBE_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_STEP  = 3'd5;

    // Parameter defaults
    localparam int DEF_MAX_COUNT = 256;
    localparam int DEF_ADDR_BITS = 22;

endpackage

`default_nettype wire

// ----- design/cac_skip.sv -----
// Skip rule for level start addresses: add the skip, keep the low address
// bits, add the wrap skip on carry in interleave mode. Uses cac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cac_skip #(
    parameter int ADDR_BITS = cac_pkg::DEF_ADDR_BITS
) (
    input  wire logic [ADDR_BITS:0]   i_base,
    input  wire logic [ADDR_BITS-1:0] i_step,
    input  wire logic                 i_interleave,
    input  wire logic [ADDR_BITS-1:0] i_wrap,
    output logic      [ADDR_BITS:0]   o_next
);
    import cac_pkg::*;

    logic [ADDR_BITS+1:0] sum;
    logic [ADDR_BITS:0]   wrap_add;

    // Add skip, test the carry bit, fold in the wrap skip
    always_comb begin
        sum      = (ADDR_BITS+2)'(i_base) + (ADDR_BITS+2)'(i_step);
        wrap_add = (i_interleave && sum[ADDR_BITS]) ? (ADDR_BITS+1)'(i_wrap)
                                                    : '0;
        o_next   = (ADDR_BITS+1)'(sum[ADDR_BITS-1:0]) + wrap_add;
    end

endmodule

`default_nettype wire

// ----- design/cube_address_generator.sv -----
// Top level of the cube address generator: stream in, stream out, config port.
// Uses cac_pkg and cac_skip.
`timescale 1ns / 1ps
`default_nettype none

// A start beat (tuser = 0) loads the base address and the four loop counts
// and gives no result; a start with any count of zero leaves the block idle,
// and a count above MAX_COUNT is clamped to it. Each next beat (tuser = 1)
// while a sequence runs gives one address, with tlast on the final address;
// a next beat while idle is dropped. The loop indices and the three level
// start addresses are updated in the cycle the beat is accepted, so one
// address comes out per cycle while the input is not stalled. Results pass
// through an output register and a one-beat skid register, so the input keeps
// flowing while a result waits; it stalls only when both hold a beat. The user
// must write configuration only with no sequence in flight; not enforced here.
module cube_address_generator #(
    parameter int MAX_COUNT = cac_pkg::DEF_MAX_COUNT,
    parameter int ADDR_BITS = cac_pkg::DEF_ADDR_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,

    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // start_address, units_per_slice, slices_per_plane, planes_per_cube,
    // cube_total, zero fill
    input  wire logic [((ADDR_BITS + 4*cac_pkg::CNT_IN_W + 7) / 8) * 8 - 1:0]
                                                 s_axis_tdata,
    // action
    input  wire logic                            s_axis_tuser,

    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // address, zero fill
    output logic [cac_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,

    input  wire logic                            i_cfg_we,
    input  wire logic [cac_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ADDR_BITS-1:0]            i_cfg_data
);
    import cac_pkg::*;

    localparam int CNT_MAX = (MAX_COUNT < 511) ? MAX_COUNT : 511;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int B_W     = ADDR_BITS + 1;

    // Configuration registers
    logic                 r_interleave;
    logic [ADDR_BITS-1:0] r_unit_step, r_slice_step, r_plane_step;
    logic [ADDR_BITS-1:0] r_cube_step, r_wrap_step;

    // Sequence state
    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_ucnt, r_scnt, r_pcnt, r_ccnt;
    logic [CNT_W-1:0] n_ucnt, n_scnt, n_pcnt, n_ccnt;
    logic [CNT_W-1:0] r_uidx, r_sidx, r_pidx, r_cidx;
    logic [CNT_W-1:0] n_uidx, n_sidx, n_pidx, n_cidx;
    logic [UA_W-1:0]  r_cur, n_cur;
    logic [B_W-1:0]   r_slice_base, r_plane_base, r_cube_base;
    logic [B_W-1:0]   n_slice_base, n_plane_base, n_cube_base;

    // Output register and skid register
    logic            r_out_valid, r_skid_valid;
    logic [UA_W-1:0] r_out_addr, r_skid_addr;
    logic            r_out_last, r_skid_last;

    logic             in_fire, is_start, res_valid, res_last, out_free;
    logic             u_end, s_end, p_end, c_end;
    logic [B_W-1:0]   start_base;
    logic [CNT_W-1:0] in_ucnt, in_scnt, in_pcnt, in_ccnt;
    logic [B_W-1:0]   sl_in, pl_in, cb_in;
    logic [B_W-1:0]   sl_next, pl_next, cb_next;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_IN_W-1:0] c);
        return (c > CNT_IN_W'(CNT_MAX)) ? CNT_W'(CNT_MAX) : CNT_W'(c);
    endfunction

    // Handshake and input unpacking
    assign s_axis_tready = !r_skid_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign is_start      = (s_axis_tuser == ACT_START);
    assign start_base    = B_W'(s_axis_tdata[ADDR_BITS-1:0]);
    assign in_ucnt = clamp_count(s_axis_tdata[ADDR_BITS + 0*CNT_IN_W +: CNT_IN_W]);
    assign in_scnt = clamp_count(s_axis_tdata[ADDR_BITS + 1*CNT_IN_W +: CNT_IN_W]);
    assign in_pcnt = clamp_count(s_axis_tdata[ADDR_BITS + 2*CNT_IN_W +: CNT_IN_W]);
    assign in_ccnt = clamp_count(s_axis_tdata[ADDR_BITS + 3*CNT_IN_W +: CNT_IN_W]);

    // Level end flags
    assign u_end    = (r_uidx == r_ucnt - CNT_W'(1));
    assign s_end    = (r_sidx == r_scnt - CNT_W'(1));
    assign p_end    = (r_pidx == r_pcnt - CNT_W'(1));
    assign c_end    = (r_cidx == r_ccnt - CNT_W'(1));
    assign res_last = u_end && s_end && p_end && c_end;
    assign res_valid = in_fire && (s_axis_tuser == ACT_NEXT) && r_busy;

    // Select the operands of the three shared skip adders
    always_comb begin
        if (is_start) begin
            sl_in = start_base;
        end else if (!s_end) begin
            sl_in = r_slice_base;
        end else if (!p_end) begin
            sl_in = r_plane_base;
        end else begin
            sl_in = r_cube_base;
        end
        pl_in = is_start ? start_base : (p_end ? r_cube_base : r_plane_base);
        cb_in = is_start ? start_base : r_cube_base;
    end

    cac_skip #(.ADDR_BITS(ADDR_BITS)) u_skip_slice (
        .i_base(sl_in), .i_step(r_slice_step), .i_interleave(r_interleave),
        .i_wrap(r_wrap_step), .o_next(sl_next)
    );
    cac_skip #(.ADDR_BITS(ADDR_BITS)) u_skip_plane (
        .i_base(pl_in), .i_step(r_plane_step), .i_interleave(r_interleave),
        .i_wrap(r_wrap_step), .o_next(pl_next)
    );
    cac_skip #(.ADDR_BITS(ADDR_BITS)) u_skip_cube (
        .i_base(cb_in), .i_step(r_cube_step), .i_interleave(r_interleave),
        .i_wrap(r_wrap_step), .o_next(cb_next)
    );

    // Next sequence state
    always_comb begin
        n_busy = r_busy;
        n_ucnt = r_ucnt; n_scnt = r_scnt; n_pcnt = r_pcnt; n_ccnt = r_ccnt;
        n_uidx = r_uidx; n_sidx = r_sidx; n_pidx = r_pidx; n_cidx = r_cidx;
        n_cur  = r_cur;
        n_slice_base = r_slice_base;
        n_plane_base = r_plane_base;
        n_cube_base  = r_cube_base;
        if (in_fire && is_start) begin
            n_ucnt = in_ucnt; n_scnt = in_scnt; n_pcnt = in_pcnt; n_ccnt = in_ccnt;
            n_uidx = '0; n_sidx = '0; n_pidx = '0; n_cidx = '0;
            n_busy = (in_ucnt != '0) && (in_scnt != '0) &&
                     (in_pcnt != '0) && (in_ccnt != '0);
            if (n_busy) begin
                n_cur        = UA_W'(start_base);
                n_slice_base = sl_next;
                n_plane_base = pl_next;
                n_cube_base  = cb_next;
            end
        end else if (res_valid) begin
            if (!u_end) begin
                n_uidx = r_uidx + CNT_W'(1);
                n_cur  = r_cur + UA_W'(r_unit_step);
            end else begin
                n_uidx = '0;
                if (!s_end) begin
                    n_sidx       = r_sidx + CNT_W'(1);
                    n_cur        = UA_W'(r_slice_base);
                    n_slice_base = sl_next;
                end else begin
                    n_sidx = '0;
                    if (!p_end) begin
                        n_pidx       = r_pidx + CNT_W'(1);
                        n_cur        = UA_W'(r_plane_base);
                        n_slice_base = sl_next;
                        n_plane_base = pl_next;
                    end else begin
                        n_pidx = '0;
                        if (!c_end) begin
                            n_cidx       = r_cidx + CNT_W'(1);
                            n_cur        = UA_W'(r_cube_base);
                            n_slice_base = sl_next;
                            n_plane_base = pl_next;
                            n_cube_base  = cb_next;
                        end else begin
                            n_cidx = '0;
                            n_busy = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interleave <= 1'b0;
            r_unit_step  <= '0;
            r_slice_step <= '0;
            r_plane_step <= '0;
            r_cube_step  <= '0;
            r_wrap_step  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INTERLEAVE: r_interleave <= i_cfg_data[0];
                CFG_UNIT_STEP:  r_unit_step  <= i_cfg_data;
                CFG_SLICE_STEP: r_slice_step <= i_cfg_data;
                CFG_PLANE_STEP: r_plane_step <= i_cfg_data;
                CFG_CUBE_STEP:  r_cube_step  <= i_cfg_data;
                CFG_WRAP_STEP:  r_wrap_step  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ucnt <= '0; r_scnt <= '0; r_pcnt <= '0; r_ccnt <= '0;
            r_uidx <= '0; r_sidx <= '0; r_pidx <= '0; r_cidx <= '0;
        end else begin
            r_busy <= n_busy;
            r_ucnt <= n_ucnt; r_scnt <= n_scnt; r_pcnt <= n_pcnt; r_ccnt <= n_ccnt;
            r_uidx <= n_uidx; r_sidx <= n_sidx; r_pidx <= n_pidx; r_cidx <= n_cidx;
        end
        r_cur        <= n_cur;
        r_slice_base <= n_slice_base;
        r_plane_base <= n_plane_base;
        r_cube_base  <= n_cube_base;
    end

    // Output register with skid stage; the skid beat is always the newer one
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= res_valid;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_addr  <= r_skid_addr;
                r_out_last  <= r_skid_last;
                r_skid_addr <= r_cur;
                r_skid_last <= res_last;
            end else begin
                r_out_addr <= r_cur;
                r_out_last <= res_last;
            end
        end else if (res_valid) begin
            r_skid_addr <= r_cur;
            r_skid_last <= res_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_addr);
    assign m_axis_tlast  = r_out_last;

    // A beat in the skid register always has an older beat ahead of it
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid beat held with empty output register");

    // A running sequence has no zero count
    a_busy_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_ucnt != '0) && (r_scnt != '0) && (r_pcnt != '0) && (r_ccnt != '0))
        else $error("running sequence with a zero count");

    // Loop indices stay below their counts while running
    a_busy_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_uidx < r_ucnt) && (r_sidx < r_scnt) &&
                   (r_pidx < r_pcnt) && (r_cidx < r_ccnt))
        else $error("loop index past its count");

    // The final address of a sequence leaves the block idle
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_last) |=> !r_busy)
        else $error("sequence still running after its final address");

endmodule

`default_nettype wire
